// ===== src/lpcw_pkg.sv =====
// Shared types and codes for the LRU page cache writeback unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package lpcw_pkg;

    // Operation kinds carried in the input tuser field
    typedef logic [2:0] kind_t;
    localparam kind_t KIND_GET    = 3'd0;
    localparam kind_t KIND_PUT    = 3'd1;
    localparam kind_t KIND_EXISTS = 3'd2;
    localparam kind_t KIND_FLUSH  = 3'd3;
    localparam kind_t KIND_CLEAR  = 3'd4;
    localparam kind_t KIND_EVICT  = 3'd5;

    // Configuration register indexes
    localparam int REG_CAPACITY = 0;

    localparam int CAP_W  = 5;
    localparam int PAGE_W = 32;
    localparam int HDL_W  = 64;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 104;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EXEC,
        ST_EVICT,
        ST_INSERT,
        ST_FLUSH,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_UPDATE,
        CMD_EVICT,
        CMD_INSERT,
        CMD_FLUSH_STEP,
        CMD_TOUCH,
        CMD_CLEAR_ALL
    } cmd_op_t;

    // Controller to datapath
    typedef struct packed {
        cmd_op_t op;
        logic    load;
        logic    emit_done;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  hit;
        logic  occ_full;
        logic  occ_zero;
        logic  flush_more;
        logic  slot_free;
    } dp_status_t;

endpackage

// ===== src/lpcw_ctrl.sv =====
// Controller state machine of the LRU page cache writeback unit.
// Depends on lpcw_pkg; drives the datapath through dp_cmd_t and reads dp_status_t.
`timescale 1ns / 1ps

module lpcw_ctrl
    import lpcw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                case (status.kind) inside
                    KIND_PUT:
                    begin
                        if (status.hit)
                        begin
                            state_next = ST_DONE;
                        end
                        else if (status.occ_full && !status.occ_zero)
                        begin
                            state_next = ST_EVICT;
                        end
                        else
                        begin
                            state_next = ST_INSERT;
                        end
                    end
                    KIND_FLUSH, KIND_CLEAR:
                    begin
                        state_next = ST_FLUSH;
                    end
                    KIND_EVICT:
                    begin
                        state_next = status.occ_zero ? ST_DONE : ST_EVICT;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_EVICT:
            begin
                if (status.slot_free)
                begin
                    state_next = (status.kind == KIND_PUT) ? ST_INSERT : ST_DONE;
                end
            end
            ST_INSERT:
            begin
                state_next = ST_DONE;
            end
            ST_FLUSH:
            begin
                if (!status.flush_more)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd          = '{op: CMD_NONE, load: 1'b0, emit_done: 1'b0};
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_EXEC:
            begin
                if (status.kind == KIND_PUT && status.hit)
                begin
                    cmd.op = CMD_UPDATE;
                end
            end
            ST_EVICT:
            begin
                if (status.slot_free)
                begin
                    cmd.op = CMD_EVICT;
                end
            end
            ST_INSERT:
            begin
                cmd.op = CMD_INSERT;
            end
            ST_FLUSH:
            begin
                if (status.flush_more && status.slot_free)
                begin
                    cmd.op = CMD_FLUSH_STEP;
                end
            end
            ST_DONE:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_done = 1'b1;
                    if (status.kind == KIND_GET)
                    begin
                        cmd.op = CMD_TOUCH;
                    end
                    else if (status.kind == KIND_CLEAR)
                    begin
                        cmd.op = CMD_CLEAR_ALL;
                    end
                end
            end
            default:
            begin
                cmd.op = CMD_NONE;
            end
        endcase
    end

endmodule

// ===== src/lpcw_dp.sv =====
// Datapath of the LRU page cache writeback unit: entry store, tag compare,
// recency ranks, occupancy, flush walk counter and the output word register.
// Depends on lpcw_pkg; driven by lpcw_ctrl.
`timescale 1ns / 1ps

module lpcw_dp
    import lpcw_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    input  kind_t                  in_kind,
    input  logic [PAGE_W-1:0]      in_page,
    input  logic [HDL_W-1:0]       in_handle,
    input  logic                   in_dirty,
    input  logic [CAP_W-1:0]       capacity,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_hit,
    output logic [HDL_W-1:0]       out_handle,
    output logic                   out_wb_valid,
    output logic [PAGE_W-1:0]      out_wb_page,
    output logic                   out_last
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    // Entry store
    logic [PAGE_W-1:0] tag_reg    [ENTRIES];
    logic [HDL_W-1:0]  handle_reg [ENTRIES];
    logic [IDX_W-1:0]  rank_reg   [ENTRIES];
    logic [IDX_W-1:0]  rank_next  [ENTRIES];
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] dirty_reg, dirty_next;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [OCC_W-1:0]  walk_reg, walk_next;

    // Latched operation
    kind_t             kind_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [HDL_W-1:0]  hdl_reg;
    logic              dirty_in_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;

    // Output word register
    logic              ov_reg, ov_next;
    logic              ohit_reg, ohit_next;
    logic [HDL_W-1:0]  ohdl_reg, ohdl_next;
    logic              owbv_reg, owbv_next;
    logic [PAGE_W-1:0] owbp_reg, owbp_next;
    logic              olast_reg, olast_next;

    logic              slot_free;
    logic              match_any;
    logic [IDX_W-1:0]  match_idx;
    logic              vic_found;
    logic [IDX_W-1:0]  vic_idx;
    logic [IDX_W-1:0]  vic_rank;
    logic              walk_found;
    logic [IDX_W-1:0]  walk_idx;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic [CMP_W-1:0]  eff_cap;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;

    assign slot_free = !ov_reg || out_ready;

    // Effective capacity, clamped to 1..ENTRIES
    always_comb
    begin
        if (capacity == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (CMP_W'(capacity) > CMP_W'(ENTRIES))
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        else
        begin
            eff_cap = CMP_W'(capacity);
        end
    end

    assign vic_rank = IDX_W'(occ_reg - OCC_W'(1));

    // Parallel tag compare and entry searches, lowest index wins
    always_comb
    begin
        match_any  = 1'b0;
        match_idx  = '0;
        vic_found  = 1'b0;
        vic_idx    = '0;
        walk_found = 1'b0;
        walk_idx   = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (!match_any && valid_reg[i] && tag_reg[i] == page_reg)
            begin
                match_any = 1'b1;
                match_idx = IDX_W'(i);
            end
            if (!vic_found && valid_reg[i] && rank_reg[i] == vic_rank)
            begin
                vic_found = 1'b1;
                vic_idx   = IDX_W'(i);
            end
            if (!walk_found && valid_reg[i] && rank_reg[i] == IDX_W'(walk_reg))
            begin
                walk_found = 1'b1;
                walk_idx   = IDX_W'(i);
            end
            if (!free_found && !valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Control state updates for each command
    always_comb
    begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        occ_next   = occ_reg;
        walk_next  = walk_reg;
        rank_next  = rank_reg;
        wr_en      = 1'b0;
        wr_idx     = hit_idx_reg;
        ov_next    = ov_reg && !out_ready;
        ohit_next  = ohit_reg;
        ohdl_next  = ohdl_reg;
        owbv_next  = owbv_reg;
        owbp_next  = owbp_reg;
        olast_next = olast_reg;

        if (cmd.load)
        begin
            walk_next = '0;
        end

        case (cmd.op) inside
            CMD_UPDATE, CMD_TOUCH:
            begin
                if (cmd.op == CMD_UPDATE || hit_reg)
                begin
                    for (int j = 0; j < ENTRIES; j++)
                    begin
                        if (valid_reg[j] && rank_reg[j] < rank_reg[hit_idx_reg])
                        begin
                            rank_next[j] = rank_reg[j] + IDX_W'(1);
                        end
                    end
                    rank_next[hit_idx_reg] = '0;
                end
                if (cmd.op == CMD_UPDATE)
                begin
                    wr_en                   = 1'b1;
                    dirty_next[hit_idx_reg] = dirty_in_reg;
                end
            end
            CMD_EVICT:
            begin
                if (vic_found)
                begin
                    if (dirty_reg[vic_idx])
                    begin
                        ov_next    = 1'b1;
                        ohit_next  = 1'b0;
                        ohdl_next  = '0;
                        owbv_next  = 1'b1;
                        owbp_next  = tag_reg[vic_idx];
                        olast_next = 1'b0;
                    end
                    valid_next[vic_idx] = 1'b0;
                    dirty_next[vic_idx] = 1'b0;
                    rank_next[vic_idx]  = '0;
                    occ_next            = occ_reg - OCC_W'(1);
                end
            end
            CMD_INSERT:
            begin
                if (free_found)
                begin
                    for (int j = 0; j < ENTRIES; j++)
                    begin
                        if (valid_reg[j])
                        begin
                            rank_next[j] = rank_reg[j] + IDX_W'(1);
                        end
                    end
                    wr_en                = 1'b1;
                    wr_idx               = free_idx;
                    valid_next[free_idx] = 1'b1;
                    dirty_next[free_idx] = dirty_in_reg;
                    rank_next[free_idx]  = '0;
                    occ_next             = occ_reg + OCC_W'(1);
                end
            end
            CMD_FLUSH_STEP:
            begin
                if (walk_found && dirty_reg[walk_idx])
                begin
                    ov_next    = 1'b1;
                    ohit_next  = 1'b0;
                    ohdl_next  = '0;
                    owbv_next  = 1'b1;
                    owbp_next  = tag_reg[walk_idx];
                    olast_next = 1'b0;
                    dirty_next[walk_idx] = 1'b0;
                end
                walk_next = walk_reg + OCC_W'(1);
            end
            CMD_CLEAR_ALL:
            begin
                valid_next = '0;
                dirty_next = '0;
                occ_next   = '0;
                for (int j = 0; j < ENTRIES; j++)
                begin
                    rank_next[j] = '0;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase

        // Completion word
        if (cmd.emit_done)
        begin
            ov_next    = 1'b1;
            ohit_next  = hit_reg && (kind_reg == KIND_GET || kind_reg == KIND_EXISTS);
            ohdl_next  = (hit_reg && kind_reg == KIND_GET) ? handle_reg[hit_idx_reg] : '0;
            owbv_next  = 1'b0;
            owbp_next  = '0;
            olast_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            dirty_reg <= '0;
            occ_reg   <= '0;
            walk_reg  <= '0;
            ov_reg    <= 1'b0;
            for (int j = 0; j < ENTRIES; j++)
            begin
                rank_reg[j] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            occ_reg   <= occ_next;
            walk_reg  <= walk_next;
            ov_reg    <= ov_next;
            rank_reg  <= rank_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg     <= in_kind;
            page_reg     <= in_page;
            hdl_reg      <= in_handle;
            dirty_in_reg <= in_dirty;
        end
        // Lookup result is taken the cycle after the load
        hit_reg     <= match_any;
        hit_idx_reg <= match_idx;
        if (wr_en)
        begin
            tag_reg[wr_idx]    <= page_reg;
            handle_reg[wr_idx] <= hdl_reg;
        end
        ohit_reg  <= ohit_next;
        ohdl_reg  <= ohdl_next;
        owbv_reg  <= owbv_next;
        owbp_reg  <= owbp_next;
        olast_reg <= olast_next;
    end

    // Status to the controller
    always_comb
    begin
        status.kind       = kind_reg;
        status.hit        = hit_reg;
        status.occ_full   = CMP_W'(occ_reg) >= eff_cap;
        status.occ_zero   = (occ_reg == '0);
        status.flush_more = (walk_reg < occ_reg);
        status.slot_free  = slot_free;
    end

    assign out_valid    = ov_reg;
    assign out_hit      = ohit_reg;
    assign out_handle   = ohdl_reg;
    assign out_wb_valid = owbv_reg;
    assign out_wb_page  = owbp_reg;
    assign out_last     = olast_reg;

endmodule

// ===== src/lru_page_cache_writeback_unit.sv =====
// Top level of the LRU page cache writeback unit: stream ports, APB register
// and the controller/datapath pair. Depends on lpcw_pkg, lpcw_ctrl and lpcw_dp.
//
// Usage: each input word on the s_ stream is one cache operation (tuser holds
// the kind: get, put, exists, flush all, clear, evict). The m_ stream returns
// the writeback words of the operation (writeback_valid set) followed by one
// completion word with tlast high that carries hit and, for a get hit, the
// handle. One operation is in flight at a time; s_tready is high only while
// the unit waits for a new word.
// Sequence: each accepted word is latched, looked up and executed. A put hit
// updates the entry; a put miss on a full cache first evicts the least recent
// entry and then inserts; an evict drops the least recent entry unless the
// cache is empty; flush and clear walk the recency ranks, one rank per cycle
// while the output register is free. The completion word follows, and the
// unit returns to idle for the next word once the completion word is in the
// output register. The output register frees the datapath as soon as a word
// is taken, so a stalled receiver simply holds the eviction, the walk or the
// completion in place. Reset empties the cache and sets capacity_in_use to
// 16. The capacity register at byte address 0 is to be written through the
// APB port only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module lru_page_cache_writeback_unit
    import lpcw_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // page_number[31:0], page_handle_in[95:32], dirty_in[96]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [2:0]             s_tuser,   // kind[2:0]
    // Output stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // page_handle_out[63:0], writeback_valid[64], writeback_page[96:65]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser,   // hit
    output logic                   m_tlast,
    // Configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [CAP_W-1:0]  cap_reg;
    dp_cmd_t           cmd;
    dp_status_t        status;
    logic              o_hit;
    logic [HDL_W-1:0]  o_handle;
    logic              o_wbv;
    logic [PAGE_W-1:0] o_wbp;

    // Capacity register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(16);
        end
        else if (psel && penable && pwrite && paddr[2] == 1'(REG_CAPACITY))
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == 1'(REG_CAPACITY)) ? {{(32 - CAP_W){1'b0}}, cap_reg} : '0;

    lpcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lpcw_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_kind      (s_tuser),
        .in_page      (s_tdata[31:0]),
        .in_handle    (s_tdata[95:32]),
        .in_dirty     (s_tdata[96]),
        .capacity     (cap_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_hit      (o_hit),
        .out_handle   (o_handle),
        .out_wb_valid (o_wbv),
        .out_wb_page  (o_wbp),
        .out_last     (m_tlast)
    );

    // Output word packing
    assign m_tdata = {7'b0, o_wbp, o_wbv, o_handle};
    assign m_tuser = o_hit;

endmodule

// ===== bench/tb_lru_page_cache_writeback_unit.sv =====
// Self-checking bench for the LRU page cache writeback unit: directed and random
// cache operations over the stream ports, capacity set through APB.
// Depends on lpcw_pkg and lru_page_cache_writeback_unit.
`timescale 1ns / 1ps

module tb_lru_page_cache_writeback_unit;
    import lpcw_pkg::*;

    localparam int     NUM_ENTRIES = 16;
    localparam kind_t  KIND_SPARE_A = 3'd6;
    localparam kind_t  KIND_SPARE_B = 3'd7;
    localparam logic [2:0] ADDR_CAPACITY = 3'(REG_CAPACITY * 4);
    localparam logic [2:0] ADDR_UNUSED   = 3'd4;

    typedef struct {
        logic        hit;
        logic [63:0] hdl;
        logic        wb_valid;
        logic [31:0] wb_page;
        logic        last;
    } cache_word_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [2:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [2:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;

    lru_page_cache_writeback_unit #(.ENTRIES(NUM_ENTRIES)) DUT (.*);

    // Shadow copy of the cache contents.
    logic [31:0] sh_tag    [NUM_ENTRIES];
    logic [63:0] sh_handle [NUM_ENTRIES];
    logic        sh_dirty  [NUM_ENTRIES];
    logic        sh_valid  [NUM_ENTRIES];
    int          sh_rank   [NUM_ENTRIES];
    int          sh_occ;
    logic [4:0]  sh_capacity;

    cache_word_t expected_words[$];
    int          mismatches;
    int          fail_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic [31:0] page_pool[24];

    // Clock.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Overall time limit.
    initial
    begin
        #(12 * 600000);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void push_word(logic hit, logic [63:0] hdl, logic wbv,
                                      logic [31:0] wbp, logic last);
        cache_word_t w;
        w.hit = hit; w.hdl = hdl; w.wb_valid = wbv; w.wb_page = wbp; w.last = last;
        expected_words.push_back(w);
    endfunction

    function automatic int find_page(logic [31:0] page);
        for (int i = 0; i < NUM_ENTRIES; i++)
            if (sh_valid[i] && sh_tag[i] == page)
                return i;
        return -1;
    endfunction

    function automatic void promote(int idx);
        int r;
        r = sh_rank[idx];
        for (int j = 0; j < NUM_ENTRIES; j++)
            if (sh_valid[j] && sh_rank[j] < r)
                sh_rank[j]++;
        sh_rank[idx] = 0;
    endfunction

    function automatic void drop_least_recent();
        if (sh_occ == 0)
            return;
        for (int j = 0; j < NUM_ENTRIES; j++)
            if (sh_valid[j] && sh_rank[j] == sh_occ - 1)
            begin
                if (sh_dirty[j])
                    push_word(1'b0, 64'd0, 1'b1, sh_tag[j], 1'b0);
                sh_valid[j] = 1'b0;
                sh_dirty[j] = 1'b0;
                sh_rank[j]  = 0;
                sh_occ--;
                return;
            end
    endfunction

    // Writebacks of dirty entries, most recent first.
    function automatic void write_back_dirty();
        for (int r = 0; r < sh_occ; r++)
            for (int j = 0; j < NUM_ENTRIES; j++)
                if (sh_valid[j] && sh_rank[j] == r && sh_dirty[j])
                begin
                    push_word(1'b0, 64'd0, 1'b1, sh_tag[j], 1'b0);
                    sh_dirty[j] = 1'b0;
                end
    endfunction

    // Expected words of one cache operation.
    function automatic void predict_cache_op(kind_t kind, logic [31:0] page,
                                             logic [63:0] hdl, logic dirty);
        int idx;
        int cap;
        idx = find_page(page);
        cap = (sh_capacity == 0) ? 1 : (sh_capacity > NUM_ENTRIES) ? NUM_ENTRIES
                                                                      : sh_capacity;
        case (kind)
            KIND_GET:
            begin
                if (idx >= 0)
                begin
                    promote(idx);
                    push_word(1'b1, sh_handle[idx], 1'b0, 32'd0, 1'b1);
                end
                else
                    push_word(1'b0, 64'd0, 1'b0, 32'd0, 1'b1);
            end
            KIND_PUT:
            begin
                if (idx >= 0)
                begin
                    sh_handle[idx] = hdl;
                    sh_dirty[idx]  = dirty;
                    promote(idx);
                end
                else
                begin
                    if (sh_occ >= cap)
                        drop_least_recent();
                    for (int j = 0; j < NUM_ENTRIES; j++)
                        if (!sh_valid[j])
                        begin
                            for (int k = 0; k < NUM_ENTRIES; k++)
                                if (sh_valid[k])
                                    sh_rank[k]++;
                            sh_valid[j]  = 1'b1;
                            sh_tag[j]    = page;
                            sh_handle[j] = hdl;
                            sh_dirty[j]  = dirty;
                            sh_rank[j]   = 0;
                            sh_occ++;
                            break;
                        end
                end
                push_word(1'b0, 64'd0, 1'b0, 32'd0, 1'b1);
            end
            KIND_EXISTS:
                push_word(idx >= 0, 64'd0, 1'b0, 32'd0, 1'b1);
            KIND_FLUSH:
            begin
                write_back_dirty();
                push_word(1'b0, 64'd0, 1'b0, 32'd0, 1'b1);
            end
            KIND_CLEAR:
            begin
                write_back_dirty();
                for (int j = 0; j < NUM_ENTRIES; j++)
                begin
                    sh_valid[j] = 1'b0;
                    sh_dirty[j] = 1'b0;
                    sh_rank[j]  = 0;
                end
                sh_occ = 0;
                push_word(1'b0, 64'd0, 1'b0, 32'd0, 1'b1);
            end
            KIND_EVICT:
            begin
                drop_least_recent();
                push_word(1'b0, 64'd0, 1'b0, 32'd0, 1'b1);
            end
            default:
                push_word(1'b0, 64'd0, 1'b0, 32'd0, 1'b1);
        endcase
    endfunction

    // Receiver: random stalls and the check of every taken word.
    always @(posedge clk)
    begin
        cache_word_t w;
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                fail_count++;
                if (mismatches < 10)
                    $display("Unexpected word: %h user %b last %b", m_tdata, m_tuser, m_tlast);
                mismatches++;
            end
            else
            begin
                w = expected_words.pop_front();
                if (m_tuser !== w.hit || m_tdata[63:0] !== w.hdl ||
                    m_tdata[64] !== w.wb_valid || m_tdata[96:65] !== w.wb_page ||
                    m_tlast !== w.last)
                begin
                    fail_count++;
                    if (mismatches < 10)
                        $display({"Mismatch: exp hit %b hdl %h wbv %b wbp %h last %b, ",
                                  "got hit %b hdl %h wbv %b wbp %h last %b"},
                                 w.hit, w.hdl, w.wb_valid, w.wb_page, w.last,
                                 m_tuser, m_tdata[63:0], m_tdata[64], m_tdata[96:65],
                                 m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // Send one operation word; called at a rising edge, returns at the accepting edge.
    task automatic send_cache_op(kind_t kind, logic [31:0] page, logic [63:0] hdl,
                                 logic dirty);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, dirty, hdl, page};
        do
            @(posedge clk);
        while (!s_tready);
        predict_cache_op(kind, page, hdl, dirty);
    endtask

    // Let the unit drain before touching its register.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_CAPACITY)
            sh_capacity = data[4:0];
    endtask

    task automatic set_capacity(logic [31:0] value);
        wait_drained();
        apb_write(ADDR_CAPACITY, value);
    endtask

    function automatic logic [31:0] pick_page();
        if ($urandom_range(9) == 0)
            return $urandom;
        return page_pool[$urandom_range(23)];
    endfunction

    function automatic logic [63:0] rand_handle();
        return {$urandom, $urandom};
    endfunction

    // Field extremes, every kind and the corner cases at full capacity.
    task automatic test_directed();
        send_idle_pct = 0; recv_stall_pct = 0;
        send_cache_op(KIND_EVICT, 32'd0, 64'd0, 1'b0);
        send_cache_op(KIND_GET, 32'd0, 64'd0, 1'b0);
        send_cache_op(KIND_PUT, 32'd0, 64'd0, 1'b0);
        send_cache_op(KIND_PUT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_cache_op(KIND_GET, 32'hFFFF_FFFF, 64'd0, 1'b0);
        send_cache_op(KIND_GET, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_cache_op(KIND_EXISTS, 32'hFFFF_FFFF, 64'd0, 1'b0);
        send_cache_op(KIND_EXISTS, 32'h1234_5678, 64'd0, 1'b0);
        // Put on a hit replaces the dirty mark without a writeback.
        send_cache_op(KIND_PUT, 32'd0, 64'hA5A5_5A5A_0F0F_F0F0, 1'b1);
        send_cache_op(KIND_PUT, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF, 1'b0);
        send_cache_op(KIND_FLUSH, 32'd0, 64'd0, 1'b0);
        send_cache_op(KIND_FLUSH, 32'd0, 64'd0, 1'b0);
        send_cache_op(KIND_SPARE_A, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_cache_op(KIND_SPARE_B, 32'd0, 64'd0, 1'b0);
        send_cache_op(KIND_PUT, 32'h0000_0100, 64'd5, 1'b1);
        send_cache_op(KIND_EVICT, 32'd0, 64'd0, 1'b0);
        // Fill past capacity so the least recent dirty entry is written back.
        for (int i = 0; i < 18; i++)
            send_cache_op(KIND_PUT, 32'h1000 + i, rand_handle(), i[0]);
        send_cache_op(KIND_CLEAR, 32'd0, 64'd0, 1'b0);
    endtask

    // Capacity extremes, out of range values and a capacity below occupancy.
    task automatic test_capacity_settings();
        for (int i = 0; i < 10; i++)
            send_cache_op(KIND_PUT, page_pool[i], rand_handle(), 1'b1);
        set_capacity(2);
        send_cache_op(KIND_PUT, 32'hCAFE_0001, rand_handle(), 1'b1);
        send_cache_op(KIND_PUT, 32'hCAFE_0002, rand_handle(), 1'b0);
        set_capacity(0);
        send_cache_op(KIND_PUT, 32'hCAFE_0003, rand_handle(), 1'b1);
        send_cache_op(KIND_PUT, 32'hCAFE_0004, rand_handle(), 1'b1);
        send_cache_op(KIND_GET, 32'hCAFE_0004, 64'd0, 1'b0);
        set_capacity(1);
        send_cache_op(KIND_PUT, 32'hCAFE_0005, rand_handle(), 1'b1);
        set_capacity(31);
        wait_drained();
        apb_write(ADDR_UNUSED, 32'd3);
        for (int i = 0; i < 17; i++)
            send_cache_op(KIND_PUT, 32'hBEEF_0000 + i, rand_handle(), 1'b1);
        send_cache_op(KIND_CLEAR, 32'd0, 64'd0, 1'b0);
    endtask

    // Random operations under one capacity and one idling pattern.
    task automatic test_random_ops(logic [31:0] capacity, int send_pct, int recv_pct,
                                   int count);
        int    roll;
        kind_t kind;
        set_capacity(capacity);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 38)      kind = KIND_GET;
            else if (roll < 76) kind = KIND_PUT;
            else if (roll < 86) kind = KIND_EXISTS;
            else if (roll < 90) kind = KIND_FLUSH;
            else if (roll < 92) kind = KIND_CLEAR;
            else if (roll < 97) kind = KIND_EVICT;
            else                kind = kind_t'($urandom_range(6, 7));
            send_cache_op(kind, pick_page(), rand_handle(), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        send_idle_pct = 0; recv_stall_pct = 0;
        mismatches = 0; fail_count = 0;
        sh_occ = 0; sh_capacity = 5'd16;
        for (int j = 0; j < NUM_ENTRIES; j++)
        begin
            sh_tag[j] = '0; sh_handle[j] = '0; sh_dirty[j] = 1'b0;
            sh_valid[j] = 1'b0; sh_rank[j] = 0;
        end
        for (int j = 0; j < 24; j++)
            page_pool[j] = (j < 2) ? {32{j[0]}} : $urandom;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_capacity_settings();
        test_random_ops(16, 0, 0, 25);
        test_random_ops(4, 88, 0, 25);
        test_random_ops(1, 0, 88, 25);
        test_random_ops(8, 7, 7, 26);

        wait_drained();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
